FILE: hdl/pwa_pkg.sv
// types and constants shared by the world bounding box pipeline
package pwa_pkg;

  localparam logic [1:0] KIND_BOX     = 2'd0;
  localparam logic [1:0] KIND_SPHERE  = 2'd1;
  localparam logic [1:0] KIND_CAPSULE = 2'd2;

  localparam int MAT_W  = 20;
  localparam int LEN_W  = 35;
  localparam int PROD_W = MAT_W + LEN_W;
  localparam int EXT_W  = 43;

  typedef struct packed {
    logic [15:0]        object_tag;
    logic [1:0]         shape_kind;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [63:0]        quat_packed;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic [30:0]        size_a;
    logic [30:0]        size_b;
    logic [30:0]        size_c;
  } obj_t;

  typedef struct packed {
    logic [15:0]        tag_out;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } aabb_t;

  typedef struct packed {
    logic [15:0]      tag;
    logic [1:0]       kind;
    logic [2:0][31:0] center;
  } side_t;

  typedef logic [2:0][2:0][MAT_W-1:0] mat_t;
  typedef logic [2:0][LEN_W-1:0]      len_t;
  typedef logic [2:0][EXT_W-1:0]      ext_t;

endpackage

FILE: hdl/pwa_prep.sv
// quaternion products, rotation magnitudes and scaled lengths (two stages)
module pwa_prep (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          obj_valid,
  input  pwa_pkg::obj_t obj,
  output logic          valid,
  output pwa_pkg::side_t side,
  output pwa_pkg::mat_t amat,
  output pwa_pkg::len_t hlen
);
  import pwa_pkg::*;

  logic               v1;
  side_t              side1;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic [2:0][46:0]   sprod;

  logic signed [15:0] qw, qx, qy, qz;
  logic [15:0]        sx, sy, sz, s0sel;
  side_t              side_in;

  function automatic logic [15:0] smag(input logic signed [15:0] s);
    smag = s[15] ? 16'(~s + 16'd1) : s;
  endfunction

  function automatic logic [MAT_W-1:0] rabs(input logic signed [34:0] v);
    logic [34:0] mg;
    mg = v[34] ? 35'(-v) : 35'(v);
    rabs = MAT_W'((mg + 35'd8192) >> 14);
  endfunction

  always_comb begin
    qw = obj.quat_packed[63:48];
    qx = obj.quat_packed[47:32];
    qy = obj.quat_packed[31:16];
    qz = obj.quat_packed[15:0];
    sx = smag(obj.scale_x);
    sy = smag(obj.scale_y);
    sz = smag(obj.scale_z);
    case (obj.shape_kind)
      KIND_SPHERE: begin
        s0sel = sx;
        if (sy > s0sel) s0sel = sy;
        if (sz > s0sel) s0sel = sz;
      end
      KIND_CAPSULE: s0sel = (sx > sz) ? sx : sz;
      default: s0sel = sx;
    endcase
    side_in.tag    = obj.object_tag;
    side_in.kind   = obj.shape_kind;
    side_in.center = {obj.center_z, obj.center_y, obj.center_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= obj_valid;
      valid <= v1;
    end
  end

  logic signed [34:0] one, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  mat_t               amat_next;
  len_t               hlen_next;

  always_comb begin
    one = 35'sd1 <<< 28;
    exx = 35'(xx);
    eyy = 35'(yy);
    ezz = 35'(zz);
    exy = 35'(xy);
    exz = 35'(xz);
    eyz = 35'(yz);
    ewx = 35'(wx);
    ewy = 35'(wy);
    ewz = 35'(wz);
    amat_next[0][0] = rabs(one - ((eyy + ezz) <<< 1));
    amat_next[0][1] = rabs((exy - ewz) <<< 1);
    amat_next[0][2] = rabs((exz + ewy) <<< 1);
    amat_next[1][0] = rabs((exy + ewz) <<< 1);
    amat_next[1][1] = rabs(one - ((exx + ezz) <<< 1));
    amat_next[1][2] = rabs((eyz - ewx) <<< 1);
    amat_next[2][0] = rabs((exz - ewy) <<< 1);
    amat_next[2][1] = rabs((eyz + ewx) <<< 1);
    amat_next[2][2] = rabs(one - ((exx + eyy) <<< 1));
    for (int i = 0; i < 3; i++) begin
      hlen_next[i] = LEN_W'((sprod[i] + 47'd2048) >> 12);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1    <= side_in;
      xx       <= qx * qx;
      yy       <= qy * qy;
      zz       <= qz * qz;
      xy       <= qx * qy;
      xz       <= qx * qz;
      yz       <= qy * qz;
      wx       <= qw * qx;
      wy       <= qw * qy;
      wz       <= qw * qz;
      sprod[0] <= 47'(obj.size_a) * 47'(s0sel);
      sprod[1] <= 47'(obj.size_b) * 47'(sy);
      sprod[2] <= 47'(obj.size_c) * 47'(sz);
      side     <= side1;
      amat     <= amat_next;
      hlen     <= hlen_next;
    end
  end

endmodule

FILE: hdl/pwa_extent.sv
// per-axis extent: matrix times half lengths, then sums by kind (two stages)
module pwa_extent (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  pwa_pkg::side_t in_side,
  input  pwa_pkg::mat_t  amat,
  input  pwa_pkg::len_t  hlen,
  output logic           valid,
  output pwa_pkg::side_t side,
  output pwa_pkg::ext_t  ext
);
  import pwa_pkg::*;

  logic                         v3;
  side_t                        side3;
  logic [LEN_W-1:0]             h0;
  logic [2:0][2:0][PROD_W-1:0]  prod;
  ext_t                         ext_next;
  logic [PROD_W+1:0]            bsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v3    <= in_valid;
      valid <= v3;
    end
  end

  always_comb begin
    bsum = '0;
    for (int i = 0; i < 3; i++) begin
      bsum = (PROD_W+2)'(prod[i][0]) + (PROD_W+2)'(prod[i][1])
           + (PROD_W+2)'(prod[i][2]) + (PROD_W+2)'(8192);
      case (side3.kind)
        KIND_BOX:     ext_next[i] = EXT_W'(bsum >> 14);
        KIND_SPHERE:  ext_next[i] = EXT_W'(h0);
        KIND_CAPSULE: ext_next[i] = EXT_W'((prod[i][1] + PROD_W'(8192)) >> 14)
                                    + EXT_W'(h0);
        default:      ext_next[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= in_side;
      h0    <= hlen[0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(amat[i][j]) * PROD_W'(hlen[j]);
        end
      end
      side <= side3;
      ext  <= ext_next;
    end
  end

endmodule

FILE: hdl/pwa_corner.sv
// corners from centre and extent with saturation, output register
module pwa_corner (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  pwa_pkg::side_t in_side,
  input  pwa_pkg::ext_t  ext,
  output logic           valid,
  output pwa_pkg::aabb_t box
);
  import pwa_pkg::*;

  logic signed [EXT_W+1:0]  lo [3];
  logic signed [EXT_W+1:0]  hi [3];
  logic signed [31:0]       lo_s [3];
  logic signed [31:0]       hi_s [3];
  aabb_t                    box_next;

  function automatic logic signed [31:0] sat(input logic signed [EXT_W+1:0] v);
    if (v > (EXT_W+2)'(32'sh7fffffff)) sat = 32'sh7fffffff;
    else if (v < -(EXT_W+2)'(64'sh80000000)) sat = 32'sh80000000;
    else sat = 32'(v);
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i]   = (EXT_W+2)'($signed(in_side.center[i])) - $signed({2'b00, ext[i]});
      hi[i]   = (EXT_W+2)'($signed(in_side.center[i])) + $signed({2'b00, ext[i]});
      lo_s[i] = sat(lo[i]);
      hi_s[i] = sat(hi[i]);
    end
    box_next.tag_out = in_side.tag;
    box_next.min_x   = lo_s[0];
    box_next.min_y   = lo_s[1];
    box_next.min_z   = lo_s[2];
    box_next.max_x   = hi_s[0];
    box_next.max_y   = hi_s[1];
    box_next.max_z   = hi_s[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box <= box_next;
    end
  end

endmodule

FILE: hdl/primitive_world_aabb.sv
// world axis-aligned bounding box of one object, five stage pipeline
//
//   channel   direction  payload  transaction when
//   obj       in         obj_t    obj_valid & obj_ready
//   aabb      out        aabb_t   aabb_valid & aabb_ready
//
// one object a cycle unless a held result stalls the pipeline
// stages: quaternion and length products, matrix magnitudes, matrix times
// half lengths, extent sums, corners with saturation
// rst clears the stage valid bits only
// a held result freezes the whole pipeline; empty stages are not dropped
module primitive_world_aabb (
  input  logic            clk,
  input  logic            rst,
  input  logic            obj_valid,
  output logic            obj_ready,
  input  pwa_pkg::obj_t   obj,
  output logic            aabb_valid,
  input  logic            aabb_ready,
  output pwa_pkg::aabb_t  aabb
);
  import pwa_pkg::*;

  logic  en;
  logic  v_prep, v_ext;
  side_t side_prep, side_ext;
  mat_t  amat;
  len_t  hlen;
  ext_t  ext;

  assign en        = !aabb_valid || aabb_ready;
  assign obj_ready = en;

  pwa_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .obj_valid (obj_valid),
    .obj       (obj),
    .valid     (v_prep),
    .side      (side_prep),
    .amat      (amat),
    .hlen      (hlen)
  );

  pwa_extent u_extent (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_prep),
    .in_side  (side_prep),
    .amat     (amat),
    .hlen     (hlen),
    .valid    (v_ext),
    .side     (side_ext),
    .ext      (ext)
  );

  pwa_corner u_corner (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_ext),
    .in_side  (side_ext),
    .ext      (ext),
    .valid    (aabb_valid),
    .box      (aabb)
  );

endmodule
